// File: sv/clkpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clkpr_pkg
// Shared constants and types for the clock page replacement unit.
// ----------------------------------------------------------------------------
package clkpr_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int FRAME_W    = 5;
    localparam int CFG_W      = 6;
    localparam int MODE_W     = 2;
    localparam int DATA_W     = 8;
    localparam int SWEEP_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACCESS  = 2'd0,
        MODE_INSTALL = 2'd1,
        MODE_PICK    = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } seq_state_t;

    // Write command into the per-frame bit store.
    typedef struct packed {
        logic             access;
        logic             install;
        logic             clear_use;
        logic             is_write;
        logic [IDX_W-1:0] idx;
    } bits_cmd_t;

    // Result strobe from the scan sequencer.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] frame;
        logic             dirty;
    } scan_res_t;

endpackage : clkpr_pkg
`default_nettype wire

// File: sv/clkpr_frame_bits.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clkpr_frame_bits
// Use and dirty bit per frame, one write command and one read port per cycle.
// ----------------------------------------------------------------------------
module clkpr_frame_bits (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire clkpr_pkg::bits_cmd_t           cmd,
    input  wire logic [clkpr_pkg::IDX_W-1:0]    rd_idx,
    output logic                                rd_use,
    output logic                                rd_dirty
);

    logic [clkpr_pkg::NUM_FRAMES-1:0] use_reg;
    logic [clkpr_pkg::NUM_FRAMES-1:0] dirty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_reg   <= '0;
            dirty_reg <= '0;
        end else if (cmd.access) begin
            use_reg[cmd.idx] <= 1'b1;
            if (cmd.is_write) begin
                dirty_reg[cmd.idx] <= 1'b1;
            end
        end else if (cmd.install) begin
            use_reg[cmd.idx]   <= 1'b0;
            dirty_reg[cmd.idx] <= 1'b0;
        end else if (cmd.clear_use) begin
            use_reg[cmd.idx] <= 1'b0;
        end
    end

    assign rd_use   = use_reg[rd_idx];
    assign rd_dirty = dirty_reg[rd_idx];

endmodule : clkpr_frame_bits
`default_nettype wire

// File: sv/clkpr_scan_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clkpr_scan_seq
// Clock hand and victim search: inspects one frame per cycle (holding on a hit
// while the output is not free) over up to four sweeps with a single compare unit.
// ----------------------------------------------------------------------------
module clkpr_scan_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           pick,
    input  wire logic [clkpr_pkg::CNT_W-1:0]    n_frames,
    input  wire logic                           rd_use,
    input  wire logic                           rd_dirty,
    input  wire logic                           out_free,
    output logic                                busy,
    output logic [clkpr_pkg::IDX_W-1:0]         rd_idx,
    output logic                                clear_use,
    output clkpr_pkg::scan_res_t                res
);

    clkpr_pkg::seq_state_t                 state_reg, state_next;
    logic [clkpr_pkg::IDX_W-1:0]           hand_reg, hand_next;
    logic [clkpr_pkg::IDX_W-1:0]           pos_reg, pos_next;
    logic [clkpr_pkg::IDX_W-1:0]           start_reg, start_next;
    logic [clkpr_pkg::SWEEP_W-1:0]         sweep_reg, sweep_next;
    logic [clkpr_pkg::IDX_W-1:0]           start_pos;
    logic [clkpr_pkg::IDX_W-1:0]           pos_inc;
    logic [clkpr_pkg::CNT_W-1:0]           pos_sum;
    logic                                  match;
    logic                                  step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clkpr_pkg::ST_IDLE;
            hand_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            sweep_reg <= sweep_next;
        end
    end

    // Restart from frame 0 when the hand lies beyond the frames in effect.
    assign start_pos = (clkpr_pkg::CNT_W'(hand_reg) < n_frames) ? hand_reg : '0;

    assign pos_sum = clkpr_pkg::CNT_W'(pos_reg) + clkpr_pkg::CNT_W'(1);
    assign pos_inc = (pos_sum == n_frames) ? '0 : pos_sum[clkpr_pkg::IDX_W-1:0];

    // Even sweeps want a clean frame, odd sweeps a dirty one.
    assign match = !rd_use && (rd_dirty == sweep_reg[0]);

    always_comb begin
        state_next = state_reg;
        hand_next  = hand_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        sweep_next = sweep_reg;
        step       = 1'b0;
        res.done   = 1'b0;
        res.frame  = pos_reg;
        res.dirty  = rd_dirty;
        unique case (state_reg)
            clkpr_pkg::ST_IDLE: begin
                if (pick) begin
                    pos_next   = start_pos;
                    start_next = start_pos;
                    sweep_next = '0;
                    state_next = clkpr_pkg::ST_SCAN;
                end
            end
            clkpr_pkg::ST_SCAN: begin
                // Hold on a hit until the output register can take the word.
                step = !match || out_free;
                if (step) begin
                    if (match) begin
                        res.done   = 1'b1;
                        hand_next  = pos_inc;
                        state_next = clkpr_pkg::ST_IDLE;
                    end else begin
                        pos_next = pos_inc;
                        if (pos_inc == start_reg) begin
                            sweep_next = sweep_reg + clkpr_pkg::SWEEP_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = clkpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != clkpr_pkg::ST_IDLE);
    assign rd_idx    = pos_reg;
    assign clear_use = step && (sweep_reg == clkpr_pkg::SWEEP_W'(1));

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == clkpr_pkg::ST_SCAN) |-> (clkpr_pkg::CNT_W'(pos_reg) < n_frames))
        else $error("scan position beyond frame count");

    a_victim_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> (!rd_use && (rd_dirty == sweep_reg[0])))
        else $error("victim does not fit the sweep");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |=> (state_reg == clkpr_pkg::ST_IDLE && hand_reg == $past(pos_inc)))
        else $error("hand not left past victim");

    a_done_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> out_free)
        else $error("result while output register full");

endmodule : clkpr_scan_seq
`default_nettype wire

// File: sv/clock_page_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Enhanced second-chance clock replacement: per-frame use/dirty bits, a clock
// hand and a one-frame-per-cycle victim search that stalls on a hit if m_* is full.
// ----------------------------------------------------------------------------
//  Port group   Dir  Contents
//  s_*          in   tuser: mode[1:0]; tdata: frame[4:0], is_write[5]
//  m_*          out  tdata: victim_frame[4:0], victim_dirty[5]
//  cfg_*        in   frames_in_use[5:0], written when cfg_we is high
//
//  Access, install and unused mode leave s_tready high.
//  A pick loads the scan start from the hand, then the compare unit inspects
//  frames in turn: at most 3 * n + 1 frames, with n the frame count after
//  clamping to 1 .. 32.
//  The result lands in an output register; a hit stalls while it is full.
//  Reset clears all bits and the hand and sets frames_in_use to 32.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [clkpr_pkg::DATA_W-1:0]    s_tdata,   // frame, is_write
    input  wire logic [clkpr_pkg::MODE_W-1:0]    s_tuser,   // mode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [clkpr_pkg::DATA_W-1:0]         m_tdata,   // victim_frame, victim_dirty
    input  wire logic                            cfg_we,
    input  wire logic [clkpr_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [clkpr_pkg::CFG_W-1:0]    cfg_reg;
    logic [clkpr_pkg::CNT_W-1:0]    n_frames;
    logic                           m_valid_reg;
    logic [clkpr_pkg::FRAME_W-1:0]  m_frame_reg;
    logic                           m_dirty_reg;
    logic                           in_fire;
    logic                           out_free;
    logic                           frame_ok;
    logic [clkpr_pkg::FRAME_W-1:0]  in_frame;
    logic                           in_write;
    clkpr_pkg::bits_cmd_t           in_cmd;
    clkpr_pkg::bits_cmd_t           cmd;
    clkpr_pkg::scan_res_t           res;
    logic                           busy;
    logic                           pick;
    logic                           clear_use;
    logic [clkpr_pkg::IDX_W-1:0]    rd_idx;
    logic                           rd_use;
    logic                           rd_dirty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= clkpr_pkg::CFG_W'(clkpr_pkg::NUM_FRAMES);
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Clamp the frame count to 1 .. NUM_FRAMES.
    always_comb begin
        if (cfg_reg == '0) begin
            n_frames = clkpr_pkg::CNT_W'(1);
        end else if (32'(cfg_reg) > clkpr_pkg::NUM_FRAMES) begin
            n_frames = clkpr_pkg::CNT_W'(clkpr_pkg::NUM_FRAMES);
        end else begin
            n_frames = clkpr_pkg::CNT_W'(cfg_reg);
        end
    end

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign in_frame = s_tdata[clkpr_pkg::FRAME_W-1:0];
    assign in_write = s_tdata[clkpr_pkg::FRAME_W];
    assign frame_ok = (32'(in_frame) < clkpr_pkg::NUM_FRAMES);

    always_comb begin
        in_cmd           = '0;
        in_cmd.is_write  = in_write;
        in_cmd.idx       = clkpr_pkg::IDX_W'(in_frame);
        pick             = 1'b0;
        if (in_fire) begin
            unique case (s_tuser)
                clkpr_pkg::MODE_ACCESS:  in_cmd.access  = frame_ok;
                clkpr_pkg::MODE_INSTALL: in_cmd.install = frame_ok;
                clkpr_pkg::MODE_PICK:    pick           = 1'b1;
                default:                 pick           = 1'b0;
            endcase
        end
    end

    // Drop to the scan's write while it runs; inputs are held off then.
    always_comb begin
        if (busy) begin
            cmd           = '0;
            cmd.clear_use = clear_use;
            cmd.idx       = rd_idx;
        end else begin
            cmd = in_cmd;
        end
    end

    clkpr_frame_bits u_bits (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_use   (rd_use),
        .rd_dirty (rd_dirty)
    );

    clkpr_scan_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pick      (pick),
        .n_frames  (n_frames),
        .rd_use    (rd_use),
        .rd_dirty  (rd_dirty),
        .out_free  (out_free),
        .busy      (busy),
        .rd_idx    (rd_idx),
        .clear_use (clear_use),
        .res       (res)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done) begin
            m_frame_reg <= clkpr_pkg::FRAME_W'(res.frame);
            m_dirty_reg <= res.dirty;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(clkpr_pkg::DATA_W - clkpr_pkg::FRAME_W - 1){1'b0}},
                       m_dirty_reg, m_frame_reg};

endmodule : clock_page_replacement_unit
`default_nettype wire
